### design/fvc_pkg.sv
// Package for the flow vector color coder: shared widths, latencies,
// the arctangent table for the angle unit and the color wheel lookup.
// No dependencies.
`timescale 1ns / 1ps

package fvc_pkg;

	// Unit step counts
	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int DIV_STEPS    = 17;

	// Fixed widths
	localparam int PRESCALE_BITS = 40;  // vector is scaled to 40-bit magnitude
	localparam int ZW            = 32;  // angle accumulator, 2^32 per turn
	localparam int DISP_W        = 15;  // 16 * max displacement
	localparam int DSQ_W         = 30;  // its square
	localparam int ROOT_W        = 31;  // isqrt of S * 2^32
	localparam int REM_W         = 34;  // square root partial remainder
	localparam int RAD_W         = 17;  // radius in Q16, up to 65536
	localparam int CH_W          = 8;
	localparam int KW            = 6;   // wheel index

	// Latencies in register stages
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int RAD_LAT    = 2 + SQRT_STEPS + DIV_STEPS;
	localparam int COLOR_LAT  = 4;

	localparam logic [ZW-1:0] ATAN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// Per-pixel side information traveling with the angle into the shader
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic             in_circle;
		logic             pix;
	} fvc_side_t;

	// Color wheel: six hue segments, entries past the last segment are black
	function automatic rgb_t wheel_color(input logic [KW-1:0] k);
		rgb_t c;
		c = '0;
		if (k < 6'd15) begin
			c.red   = 8'd255;
			c.green = 8'({2'b00, k}) * 8'd17;
			c.blue  = 8'd0;
		end else begin
			case (k)
				6'd15: c = {8'd255, 8'd255, 8'd0};
				6'd16: c = {8'd213, 8'd255, 8'd0};
				6'd17: c = {8'd170, 8'd255, 8'd0};
				6'd18: c = {8'd128, 8'd255, 8'd0};
				6'd19: c = {8'd85,  8'd255, 8'd0};
				6'd20: c = {8'd43,  8'd255, 8'd0};
				6'd21: c = {8'd0,   8'd255, 8'd0};
				6'd22: c = {8'd0,   8'd255, 8'd63};
				6'd23: c = {8'd0,   8'd255, 8'd127};
				6'd24: c = {8'd0,   8'd255, 8'd191};
				6'd25: c = {8'd0,   8'd255, 8'd255};
				6'd26: c = {8'd0,   8'd232, 8'd255};
				6'd27: c = {8'd0,   8'd209, 8'd255};
				6'd28: c = {8'd0,   8'd186, 8'd255};
				6'd29: c = {8'd0,   8'd163, 8'd255};
				6'd30: c = {8'd0,   8'd140, 8'd255};
				6'd31: c = {8'd0,   8'd116, 8'd255};
				6'd32: c = {8'd0,   8'd93,  8'd255};
				6'd33: c = {8'd0,   8'd70,  8'd255};
				6'd34: c = {8'd0,   8'd47,  8'd255};
				6'd35: c = {8'd0,   8'd24,  8'd255};
				6'd36: c = {8'd0,   8'd0,   8'd255};
				6'd37: c = {8'd19,  8'd0,   8'd255};
				6'd38: c = {8'd39,  8'd0,   8'd255};
				6'd39: c = {8'd58,  8'd0,   8'd255};
				6'd40: c = {8'd78,  8'd0,   8'd255};
				6'd41: c = {8'd98,  8'd0,   8'd255};
				6'd42: c = {8'd117, 8'd0,   8'd255};
				6'd43: c = {8'd137, 8'd0,   8'd255};
				6'd44: c = {8'd156, 8'd0,   8'd255};
				6'd45: c = {8'd176, 8'd0,   8'd255};
				6'd46: c = {8'd196, 8'd0,   8'd255};
				6'd47: c = {8'd215, 8'd0,   8'd255};
				6'd48: c = {8'd235, 8'd0,   8'd255};
				6'd49: c = {8'd255, 8'd0,   8'd255};
				6'd50: c = {8'd255, 8'd0,   8'd213};
				6'd51: c = {8'd255, 8'd0,   8'd170};
				6'd52: c = {8'd255, 8'd0,   8'd128};
				6'd53: c = {8'd255, 8'd0,   8'd85};
				6'd54: c = {8'd255, 8'd0,   8'd43};
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage

### design/flow_vector_to_color_core.sv
// Top level of the flow vector color coder.
// Instantiates fvc_cordic, fvc_radius and fvc_color; depends on fvc_pkg.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid/in_ready): one flow vector per transaction,
//   flow_u and flow_v signed with 4 fractional bits, pixel_valid low gives
//   black. Output channel (out_valid/out_ready): one blue/green/red triple
//   per input transaction, in order.
// - Config channel (cfg_valid/cfg_ready): writes max_displacement, always
//   ready; write only while no pixel is in flight. Zero acts as one.
// - Pipeline: an input transaction reaches out_valid through the
//   50-stage radius path (squares, 31-step square root, 17-step divide)
//   plus 4 shading stages and the output register. The 31-stage angle
//   unit is delayed to match.
// - Throughput: one pixel per cycle while out_ready is high.
// - Stall: when the output register holds a result and out_ready is low,
//   the whole pipeline freezes and in_ready drops; nothing is lost.
// - Reset: pipeline emptied, out_valid low, max_displacement back to 1.

module flow_vector_to_color_core import fvc_pkg::*; #(
	parameter int FLOW_WIDTH    = 16,
	parameter int ANGLE_BITS    = 16,
	parameter int WHEEL_ENTRIES = 55
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [FLOW_WIDTH-1:0] flow_u,
	input  logic signed [FLOW_WIDTH-1:0] flow_v,
	input  logic                         pixel_valid,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CH_W-1:0]              blue,
	output logic [CH_W-1:0]              green,
	output logic [CH_W-1:0]              red,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [10:0]                  max_displacement
);

	localparam int PIPE_LAT = RAD_LAT + COLOR_LAT;
	localparam int Z_DELAY  = RAD_LAT - CORDIC_LAT;

	logic                en;
	logic [DISP_W-1:0]   d_q, d_new;
	logic [DSQ_W-1:0]    dsq_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic                out_valid_q;
	logic [RAD_LAT-1:0]  pix_q;
	logic [ZW-1:0]       z_cordic;
	logic [ZW-1:0]       z_dly_q [Z_DELAY];
	logic [RAD_W-1:0]    rad;
	logic                in_circle;
	fvc_side_t           side;
	rgb_t                color;
	rgb_t                color_q;

	// Global advance: move unless the output holds a result nobody takes
	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Displacement scale and its square
	assign d_new = (max_displacement == '0) ? DISP_W'(16) : {max_displacement, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= DISP_W'(16);
			dsq_q <= DSQ_W'(256);
		end else if (cfg_valid) begin
			d_q   <= d_new;
			dsq_q <= DSQ_W'(d_new) * DSQ_W'(d_new);
		end
	end

	// Valid bits alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[PIPE_LAT-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_LAT-1];
		end
	end

	// Mask bit and angle delayed to meet the radius
	always_ff @(posedge clk) begin
		if (en) begin
			pix_q      <= {pix_q[RAD_LAT-2:0], pixel_valid};
			z_dly_q[0] <= z_cordic;
			for (int i = 1; i < Z_DELAY; i++)
				z_dly_q[i] <= z_dly_q[i-1];
		end
	end

	fvc_cordic #(
		.FLOW_WIDTH(FLOW_WIDTH)
	) u_cordic (
		.clk   (clk),
		.en    (en),
		.u     (flow_u),
		.v     (flow_v),
		.angle (z_cordic)
	);

	fvc_radius #(
		.FLOW_WIDTH(FLOW_WIDTH)
	) u_radius (
		.clk       (clk),
		.en        (en),
		.u         (flow_u),
		.v         (flow_v),
		.d         (d_q),
		.dsq       (dsq_q),
		.rad       (rad),
		.in_circle (in_circle)
	);

	assign side = '{rad: rad, in_circle: in_circle, pix: pix_q[RAD_LAT-1]};

	fvc_color #(
		.ANGLE_BITS   (ANGLE_BITS),
		.WHEEL_ENTRIES(WHEEL_ENTRIES)
	) u_color (
		.clk   (clk),
		.en    (en),
		.angle (z_dly_q[Z_DELAY-1]),
		.side  (side),
		.color (color)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (en)
			color_q <= color;
	end

	assign out_valid = out_valid_q;
	assign blue      = color_q.blue;
	assign green     = color_q.green;
	assign red       = color_q.red;

	// A stall freezes the in-flight valid bits
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	// An empty pipeline drains the output after a taken result
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && vld_q == '0) |=> !out_valid_q)
		else $error("result appeared from an empty pipeline");

	// Scale register and its square stay consistent
	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		d_q != '0 && d_q[3:0] == 4'b0000 && dsq_q == DSQ_W'(DSQ_W'(d_q) * DSQ_W'(d_q)))
		else $error("displacement scale inconsistent");

endmodule

### design/fvc_cordic.sv
// Pipelined CORDIC vectoring unit: direction of a flow vector in turns.
// One prescale stage plus one stage per iteration. Depends on fvc_pkg.
`timescale 1ns / 1ps

module fvc_cordic import fvc_pkg::*; #(
	parameter int FLOW_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [FLOW_WIDTH-1:0] u,
	input  logic signed [FLOW_WIDTH-1:0] v,
	output logic [ZW-1:0]                angle
);

	localparam int XW = PRESCALE_BITS + 3;
	localparam int SH = PRESCALE_BITS - FLOW_WIDTH;

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	logic [ZW-1:0]        z_s [0:CORDIC_STEPS];
	logic                 hold_s [0:CORDIC_STEPS];

	logic signed [XW-1:0] xe, ye;

	// Prescale to 40-bit magnitude
	always_comb begin
		xe = XW'(u);
		ye = XW'(v);
		xe = xe <<< SH;
		ye = ye <<< SH;
	end

	// Fold the left half plane onto the right; a horizontal vector skips rotation
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= u[FLOW_WIDTH-1] ? -xe : xe;
			y_s[0]    <= u[FLOW_WIDTH-1] ? -ye : ye;
			z_s[0]    <= u[FLOW_WIDTH-1] ? {1'b1, {(ZW-1){1'b0}}} : '0;
			hold_s[0] <= (v == '0);
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= hold_s[i] ? z_s[i] : z_s[i] + ATAN[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= hold_s[i] ? z_s[i] : z_s[i] - ATAN[i];
				end
				hold_s[i+1] <= hold_s[i];
			end
		end
	end

	assign angle = z_s[CORDIC_STEPS];

endmodule

### design/fvc_radius.sv
// Radius unit: squared magnitude, unit circle test, digit-by-digit square
// root and restoring divide by the displacement scale. Depends on fvc_pkg.
`timescale 1ns / 1ps

module fvc_radius import fvc_pkg::*; #(
	parameter int FLOW_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [FLOW_WIDTH-1:0] u,
	input  logic signed [FLOW_WIDTH-1:0] v,
	input  logic [DISP_W-1:0]            d,
	input  logic [DSQ_W-1:0]             dsq,
	output logic [RAD_W-1:0]             rad,
	output logic                         in_circle
);

	localparam int SW = 2 * FLOW_WIDTH + 1;
	localparam int CW = (SW > DSQ_W) ? SW : DSQ_W;

	logic [FLOW_WIDTH-1:0]   au, av;
	logic [2*FLOW_WIDTH-1:0] squ_s1, sqv_s1;
	logic [CW-1:0]           sum;
	logic [DSQ_W-1:0]        s_s2;
	logic                    in_s2;

	// Square root pipeline, index 0 unused (fed from stage 2)
	logic [REM_W-1:0]  rem_q [1:SQRT_STEPS];
	logic [ROOT_W-1:0] root_q [1:SQRT_STEPS];
	logic [DSQ_W-1:0]  sv_q [1:SQRT_STEPS];
	logic              sin_q [1:SQRT_STEPS];

	// Divider pipeline
	logic [DISP_W-1:0] dp_q [1:DIV_STEPS];
	logic [ROOT_W-1:0] dr_q [1:DIV_STEPS];
	logic [RAD_W-1:0]  dq_q [1:DIV_STEPS];
	logic              din_q [1:DIV_STEPS];

	// Magnitudes and squares
	assign au = u[FLOW_WIDTH-1] ? FLOW_WIDTH'(-u) : FLOW_WIDTH'(u);
	assign av = v[FLOW_WIDTH-1] ? FLOW_WIDTH'(-v) : FLOW_WIDTH'(v);

	always_ff @(posedge clk) begin
		if (en) begin
			squ_s1 <= (2*FLOW_WIDTH)'(au) * (2*FLOW_WIDTH)'(au);
			sqv_s1 <= (2*FLOW_WIDTH)'(av) * (2*FLOW_WIDTH)'(av);
		end
	end

	// Sum and unit circle test; outside the circle the root is not needed
	assign sum = CW'(squ_s1) + CW'(sqv_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			in_s2 <= sum <= CW'(dsq);
			s_s2  <= (sum <= CW'(dsq)) ? sum[DSQ_W-1:0] : '0;
		end
	end

	// isqrt of {S, 32'b0}, one result bit per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [REM_W-1:0]         rem_in;
		logic [ROOT_W-1:0]        root_in;
		logic [DSQ_W-1:0]         sv_in;
		logic                     sin_in;
		logic [DSQ_W+ZW-1:0]      nn;
		logic [REM_W-1:0]         remsh, trial;
		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign sv_in   = s_s2;
			assign sin_in  = in_s2;
		end else begin : g_next
			assign rem_in  = rem_q[j];
			assign root_in = root_q[j];
			assign sv_in   = sv_q[j];
			assign sin_in  = sin_q[j];
		end
		assign nn    = {sv_in, {ZW{1'b0}}};
		assign remsh = {rem_in[REM_W-3:0], nn[DSQ_W+ZW-1-2*j -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (remsh >= trial) begin
					rem_q[j+1]  <= remsh - trial;
					root_q[j+1] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[j+1]  <= remsh;
					root_q[j+1] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				sv_q[j+1]  <= sv_in;
				sin_q[j+1] <= sin_in;
			end
		end
	end

	// Root / D; quotient is below 2^17 so the top bits start the remainder
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DISP_W-1:0] dp_in;
		logic [ROOT_W-1:0] dr_in;
		logic [RAD_W-1:0]  dq_in;
		logic              din_in;
		logic [DISP_W:0]   t;
		logic              ge;
		if (k == 0) begin : g_first
			assign dp_in  = {1'b0, root_q[SQRT_STEPS][ROOT_W-1:RAD_W]};
			assign dr_in  = root_q[SQRT_STEPS];
			assign dq_in  = '0;
			assign din_in = sin_q[SQRT_STEPS];
		end else begin : g_next
			assign dp_in  = dp_q[k];
			assign dr_in  = dr_q[k];
			assign dq_in  = dq_q[k];
			assign din_in = din_q[k];
		end
		assign t  = {dp_in, dr_in[RAD_W-1-k]};
		assign ge = t >= {1'b0, d};
		always_ff @(posedge clk) begin
			if (en) begin
				dp_q[k+1]  <= ge ? DISP_W'(t - {1'b0, d}) : t[DISP_W-1:0];
				dq_q[k+1]  <= {dq_in[RAD_W-2:0], ge};
				dr_q[k+1]  <= dr_in;
				din_q[k+1] <= din_in;
			end
		end
	end

	assign rad       = dq_q[DIV_STEPS];
	assign in_circle = din_q[DIV_STEPS];

endmodule

### design/fvc_color.sv
// Shader: wheel index and fraction from the angle, linear interpolation
// between wheel entries, desaturation by the radius or dimming outside the circle.
// Depends on fvc_pkg.
`timescale 1ns / 1ps

module fvc_color import fvc_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int WHEEL_ENTRIES = 55
) (
	input  logic            clk,
	input  logic            en,
	input  logic [ZW-1:0]   angle,
	input  fvc_side_t       side,
	output rgb_t            color
);

	localparam int AB  = ANGLE_BITS;
	localparam int PW  = AB + KW;
	localparam int CW  = AB + CH_W;
	localparam int PRW = AB + CH_W + 1;
	localparam int MW  = RAD_W + CW;
	localparam logic [CW-1:0] FULL = CW'(255) << AB;

	logic [PW-1:0]   p;
	logic [KW-1:0]   k0_c1;
	logic [AB-1:0]   f_c1;
	fvc_side_t       side_c1, side_c2, side_c3, side_c4;
	rgb_t            col0, col1;
	logic [AB:0]     wf, wi;
	logic [PRW-1:0]  p0_c2 [3];
	logic [PRW-1:0]  p1_c2 [3];
	logic [CW-1:0]   c_c3 [3];
	logic [CW-1:0]   diff_c3 [3];
	logic [MW-1:0]   m_c4 [3];
	logic [CH_W-1:0] o_c4 [3];

	// Stage 1: wheel position
	assign p = PW'(angle[ZW-1 -: AB]) * PW'(WHEEL_ENTRIES - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			k0_c1   <= p[PW-1:AB];
			f_c1    <= p[AB-1:0];
			side_c1 <= side;
		end
	end

	// Stage 2: neighboring entries and interpolation weights
	assign col0 = wheel_color(k0_c1);
	assign col1 = wheel_color(k0_c1 + KW'(1));
	assign wf   = {1'b0, f_c1};
	assign wi   = {1'b1, {AB{1'b0}}} - wf;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				p0_c2[ch] <= PRW'(col0[ch*CH_W +: CH_W]) * PRW'(wi);
				p1_c2[ch] <= PRW'(col1[ch*CH_W +: CH_W]) * PRW'(wf);
			end
			side_c2 <= side_c1;
		end
	end

	// Stage 3: interpolated channel scaled by 2^AB and its distance to white
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				c_c3[ch]    <= CW'(p0_c2[ch] + p1_c2[ch]);
				diff_c3[ch] <= FULL - CW'(p0_c2[ch] + p1_c2[ch]);
			end
			side_c3 <= side_c2;
		end
	end

	// Stage 4: radius times distance; dimmed value for outside the circle
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				m_c4[ch] <= MW'(side_c3.rad) * MW'(diff_c3[ch]);
				o_c4[ch] <= CH_W'(((CW+2)'(c_c3[ch]) * (CW+2)'(3)) >> (AB + 2));
			end
			side_c4 <= side_c3;
		end
	end

	// Final blend, saturation and mask
	always_comb begin
		logic [MW-1:0] num;
		logic [MW-1:0] val;
		color = '0;
		for (int ch = 0; ch < 3; ch++) begin
			num = (MW'(FULL) << 16) - m_c4[ch];
			val = num >> (AB + 16);
			if (!side_c4.pix) begin
				color[ch*CH_W +: CH_W] = '0;
			end else if (side_c4.in_circle) begin
				color[ch*CH_W +: CH_W] = (val > MW'(255)) ? 8'd255 : val[CH_W-1:0];
			end else begin
				color[ch*CH_W +: CH_W] = o_c4[ch];
			end
		end
	end

endmodule
